### design/etf_pkg.sv
// Shared constants, config register codes and controller/datapath command types
// for the escape-time fractal iterator. No dependencies.
package etf_pkg;

    localparam int COORD_BITS     = 32;
    localparam int FRACTION_BITS  = 28;
    localparam int ITER_BITS      = 16;
    localparam int THRESH_BITS    = 36;
    localparam int KIND_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 36;

    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int RE_SH_BITS   = PROD_BITS - FRACTION_BITS;
    localparam int IM_SH_BITS   = PROD_BITS - FRACTION_BITS + 1;
    localparam int RE_SUM_BITS  = RE_SH_BITS + 1;
    localparam int IM_SUM_BITS  = IM_SH_BITS + 1;
    localparam int MAG_BITS     = PROD_BITS - FRACTION_BITS;

    localparam logic [KIND_BITS-1:0] KIND_MANDELBROT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_JULIA      = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_SHIP       = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_KIND      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JULIA_RE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JULIA_IM  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ITER  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 3'd4;

    localparam logic [ITER_BITS-1:0]   MAX_ITER_RESET  = 16'd100;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 36'd1073741824;

    typedef struct packed {
        logic load;         // capture a new point, iteration 0
        logic fold;         // register multiplier operands (folded for burning ship)
        logic mul;          // register the three products
        logic step;         // write new z, advance iteration
        logic finish;       // load the output register
        logic fin_escaped;
        logic fin_prev;     // escape belongs to the previous iteration
    } t_cmd;

    typedef struct packed {
        logic mag_esc;      // previous iteration's magnitude over threshold
        logic limit_hit;
        logic fold_bad;
        logic overflow;
    } t_status;

endpackage

### design/etf_dp.sv
// Datapath of the escape-time fractal iterator: config registers, z/c
// registers, three product registers, update/escape logic, output register. Uses etf_pkg.
module etf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [etf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [etf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [etf_pkg::COORD_BITS-1:0]      i_point_re,
    input  logic [etf_pkg::COORD_BITS-1:0]      i_point_im,
    input  etf_pkg::t_cmd                       i_cmd,
    output etf_pkg::t_status                    o_status,
    output logic                                o_escaped,
    output logic [etf_pkg::ITER_BITS-1:0]       o_escape_iteration
);

    localparam logic [etf_pkg::COORD_BITS-1:0] MINV = {1'b1, {(etf_pkg::COORD_BITS-1){1'b0}}};

    logic [etf_pkg::KIND_BITS-1:0]    r_kind;
    logic [etf_pkg::COORD_BITS-1:0]   r_jre, r_jim;
    logic [etf_pkg::ITER_BITS-1:0]    r_max;
    logic [etf_pkg::THRESH_BITS-1:0]  r_thr;

    logic signed [etf_pkg::COORD_BITS-1:0] r_zx, r_zy, r_cx, r_cy, r_ox, r_oy;
    logic signed [etf_pkg::PROD_BITS-1:0]  r_xx, r_yy, r_xy;
    logic [etf_pkg::ITER_BITS-1:0]         r_iter;
    logic                                  r_have_prev;
    logic                                  r_fold_bad;
    logic                                  r_esc;
    logic [etf_pkg::ITER_BITS-1:0]         r_esc_iter;

    logic                                   ship;
    logic signed [etf_pkg::COORD_BITS-1:0]  n_ox, n_oy;
    logic                                   n_fold_bad;
    logic signed [etf_pkg::PROD_BITS-1:0]   diff;
    logic [etf_pkg::PROD_BITS-1:0]          sum;
    logic signed [etf_pkg::RE_SH_BITS-1:0]  re_sh;
    logic signed [etf_pkg::IM_SH_BITS-1:0]  im_sh;
    logic signed [etf_pkg::RE_SUM_BITS-1:0] re_sum;
    logic signed [etf_pkg::IM_SUM_BITS-1:0] im_sum;
    logic [etf_pkg::MAG_BITS-1:0]           mag;
    logic                                   re_fits, im_fits;
    logic [etf_pkg::ITER_BITS-1:0]          n_esc_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= etf_pkg::KIND_MANDELBROT;
            r_jre  <= '0;
            r_jim  <= '0;
            r_max  <= etf_pkg::MAX_ITER_RESET;
            r_thr  <= etf_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                etf_pkg::CFG_KIND:      r_kind <= i_cfg_data[etf_pkg::KIND_BITS-1:0];
                etf_pkg::CFG_JULIA_RE:  r_jre  <= i_cfg_data[etf_pkg::COORD_BITS-1:0];
                etf_pkg::CFG_JULIA_IM:  r_jim  <= i_cfg_data[etf_pkg::COORD_BITS-1:0];
                etf_pkg::CFG_MAX_ITER:  r_max  <= i_cfg_data[etf_pkg::ITER_BITS-1:0];
                etf_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data[etf_pkg::THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign ship = (r_kind == etf_pkg::KIND_SHIP);

    always_comb begin
        n_fold_bad = ship && ((r_zx == MINV) || (r_zy == MINV));
        n_ox = (ship && r_zx[etf_pkg::COORD_BITS-1]) ? -r_zx : r_zx;
        n_oy = (ship && r_zy[etf_pkg::COORD_BITS-1]) ? -r_zy : r_zy;
    end

    // |products| <= 2^62, so the shifted values fit the narrowed slices exactly
    always_comb begin
        diff   = r_xx - r_yy;
        sum    = r_xx + r_yy;
        re_sh  = diff[etf_pkg::PROD_BITS-1:etf_pkg::FRACTION_BITS];
        im_sh  = r_xy[etf_pkg::PROD_BITS-1:etf_pkg::FRACTION_BITS-1];
        re_sum = etf_pkg::RE_SUM_BITS'(re_sh) + etf_pkg::RE_SUM_BITS'(r_cx);
        im_sum = etf_pkg::IM_SUM_BITS'(im_sh) + etf_pkg::IM_SUM_BITS'(r_cy);
        mag    = sum[etf_pkg::PROD_BITS-1:etf_pkg::FRACTION_BITS];
        re_fits = (re_sum[etf_pkg::RE_SUM_BITS-1:etf_pkg::COORD_BITS-1] == '0) ||
                  (re_sum[etf_pkg::RE_SUM_BITS-1:etf_pkg::COORD_BITS-1] == '1);
        im_fits = (im_sum[etf_pkg::IM_SUM_BITS-1:etf_pkg::COORD_BITS-1] == '0) ||
                  (im_sum[etf_pkg::IM_SUM_BITS-1:etf_pkg::COORD_BITS-1] == '1);
    end

    always_comb begin
        o_status.mag_esc   = r_have_prev && (mag > r_thr);
        o_status.limit_hit = (r_iter == r_max);
        o_status.fold_bad  = r_fold_bad;
        o_status.overflow  = !re_fits || !im_fits;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zx <= i_point_re;
            r_zy <= i_point_im;
            r_cx <= (r_kind == etf_pkg::KIND_JULIA) ? r_jre : i_point_re;
            r_cy <= (r_kind == etf_pkg::KIND_JULIA) ? r_jim : i_point_im;
        end else if (i_cmd.step) begin
            r_zx <= re_sum[etf_pkg::COORD_BITS-1:0];
            r_zy <= im_sum[etf_pkg::COORD_BITS-1:0];
        end
        if (i_cmd.fold) begin
            r_ox       <= n_ox;
            r_oy       <= n_oy;
            r_fold_bad <= n_fold_bad;
        end
        if (i_cmd.mul) begin
            r_xx <= r_ox * r_ox;
            r_yy <= r_oy * r_oy;
            r_xy <= r_ox * r_oy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter      <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.load) begin
            r_iter      <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.step) begin
            r_iter      <= r_iter + 1'b1;
            r_have_prev <= 1'b1;
        end
    end

    always_comb begin
        if (!i_cmd.fin_escaped) begin
            n_esc_iter = '0;
        end else if (i_cmd.fin_prev) begin
            n_esc_iter = r_iter - 1'b1;
        end else begin
            n_esc_iter = r_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_esc      <= i_cmd.fin_escaped;
            r_esc_iter <= n_esc_iter;
        end
    end

    assign o_escaped          = r_esc;
    assign o_escape_iteration = r_esc_iter;

endmodule

### design/etf_ctrl.sv
// Controller of the escape-time fractal iterator: one-hot sequencer over
// fold, multiply and update steps, plus the output valid flag. Uses etf_pkg.
module etf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    input  etf_pkg::t_status   i_status,
    output etf_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FOLD = 4'b0010,
        S_MUL  = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free  = !r_m_valid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                // the previous iteration's magnitude test ranks above this one's checks
                priority if (i_status.mag_esc) begin
                    o_cmd.fin_escaped = 1'b1;
                    o_cmd.fin_prev    = 1'b1;
                    o_cmd.finish      = out_free;
                end else if (i_status.limit_hit) begin
                    o_cmd.finish = out_free;
                end else if (i_status.fold_bad || i_status.overflow) begin
                    o_cmd.fin_escaped = 1'b1;
                    o_cmd.finish      = out_free;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_FOLD;
                end
                if (o_cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.finish) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

### design/escape_time_fractal_iterator_unit.sv
// Escape-time fractal iterator: an accept step, then per iteration a fold, multiply
// and update step around the three shared product registers. A magnitude escape at k
// is found in the update step of iteration k+1, a range/fold escape at k in the update
// step of iteration k, an inside point when the iteration count reaches max.
// One item at a time; the next item is accepted while a result waits.
// Synchronous active-low reset: idle, no result, config to reset values.
module escape_time_fractal_iterator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*etf_pkg::COORD_BITS-1:0]    s_axis_tdata,   // point_re, point_im
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [etf_pkg::ITER_BITS-1:0]       m_axis_tdata,   // escape_iteration
    output logic                                m_axis_tuser,   // escaped
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [etf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [etf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    etf_pkg::t_cmd    cmd;
    etf_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    etf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    etf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_point_re         (s_axis_tdata[etf_pkg::COORD_BITS-1:0]),
        .i_point_im         (s_axis_tdata[2*etf_pkg::COORD_BITS-1:etf_pkg::COORD_BITS]),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_escaped          (m_axis_tuser),
        .o_escape_iteration (m_axis_tdata)
    );

endmodule

### design/etf_checker.sv
// Port-level checker for the escape-time fractal iterator, bound to the top level.
// Uses etf_pkg for widths.
module etf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [etf_pkg::ITER_BITS-1:0]       m_axis_tdata,
    input logic                                m_axis_tuser
);

    // an inside point always reports iteration zero
    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("inside result with nonzero iteration");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // an accept never registers a result at once: with the output free, valid stays low
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready))
        |=> !m_axis_tvalid)
        else $error("result too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind escape_time_fractal_iterator_unit etf_checker u_etf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
